// ===== src/sactl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared types and constants of the set-associative cache tag lookup.
// ----------------------------------------------------------------------------
package sactl_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int NUM_WAYS_DEF = 8;
  localparam int TAG_BITS_DEF = 28;

  localparam int          SEED_W     = 16;
  localparam logic [15:0] SEED_RESET = 16'h0001;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    logic hit;
    logic filled;
    logic evicted;
  } sactl_res_t;

endpackage

// ===== src/sactl_dir_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_dir_mem
// Directory memory, one row per set: valid bits and tags of all ways.
// Registered read port, one write port, valid clear sweep after reset.
// ----------------------------------------------------------------------------
module sactl_dir_mem
  import sactl_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int SET_BITS = $clog2(NUM_SETS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [SET_BITS-1:0]          rd_addr_i,
  output logic [NUM_WAYS-1:0]          rd_valid_o,
  output logic [NUM_WAYS*TAG_BITS-1:0] rd_tags_o,
  input  logic                         wr_en_i,
  input  logic [SET_BITS-1:0]          wr_addr_i,
  input  logic [NUM_WAYS-1:0]          wr_valid_i,
  input  logic [NUM_WAYS*TAG_BITS-1:0] wr_tags_i,
  output logic                         busy_o
);

  logic [NUM_WAYS-1:0]          valid_mem [NUM_SETS];
  logic [NUM_WAYS*TAG_BITS-1:0] tag_mem   [NUM_SETS];

  logic                clearing_q;
  logic [SET_BITS-1:0] clr_idx_q;

  // clear sweep over all rows after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      if (clr_idx_q == SET_BITS'(NUM_SETS - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + SET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      valid_mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      valid_mem[wr_addr_i] <= wr_valid_i;
      tag_mem[wr_addr_i]   <= wr_tags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_valid_o <= valid_mem[rd_addr_i];
      rd_tags_o  <= tag_mem[rd_addr_i];
    end
  end

  assign busy_o = clearing_q;

endmodule

// ===== src/sactl_lfsr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_lfsr
// Replacement LFSR (16-bit Galois) with a registered victim way.
// ----------------------------------------------------------------------------
module sactl_lfsr
  import sactl_pkg::*;
#(
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  localparam int WAY_BITS = $clog2(NUM_WAYS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SEED_W-1:0]   seed_i,
  input  logic                advance_i,
  output logic [WAY_BITS-1:0] victim_o
);

  // floor(x / NUM_WAYS) for 16-bit x by reciprocal
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(NUM_WAYS) - 64'd1) / 64'(NUM_WAYS));

  logic [SEED_W-1:0]   lfsr_q, lfsr_d;
  logic [WAY_BITS-1:0] victim_q, victim_d;
  logic [48:0]         prod;
  logic [SEED_W-1:0]   quot;
  logic [31:0]         back;
  logic [SEED_W-1:0]   rem;

  always_comb begin
    if (cfg_we_i) begin
      lfsr_d = (seed_i == '0) ? SEED_RESET : seed_i;
    end else if (advance_i) begin
      lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
    end else begin
      lfsr_d = lfsr_q;
    end
  end

  always_comb begin
    prod     = 49'(lfsr_d) * 49'(RECIP);
    quot     = prod[47:32];
    back     = 32'(quot) * 32'(NUM_WAYS);
    rem      = lfsr_d - back[SEED_W-1:0];
    victim_d = rem[WAY_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q   <= SEED_RESET;
      victim_q <= WAY_BITS'(1);
    end else begin
      lfsr_q   <= lfsr_d;
      victim_q <= victim_d;
    end
  end

  assign victim_o = victim_q;

endmodule

// ===== src/sactl_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_lookup
// Tag compare and fill decision for one set row, plus the updated row.
// ----------------------------------------------------------------------------
module sactl_lookup
  import sactl_pkg::*;
#(
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int WAY_BITS = $clog2(NUM_WAYS)
) (
  input  logic                         opcode_i,
  input  logic [TAG_BITS-1:0]          tag_i,
  input  logic [NUM_WAYS-1:0]          row_valid_i,
  input  logic [NUM_WAYS*TAG_BITS-1:0] row_tags_i,
  input  logic [WAY_BITS-1:0]          victim_i,
  output sactl_res_t                   res_o,
  output logic [WAY_BITS-1:0]          way_o,
  output logic [NUM_WAYS-1:0]          new_valid_o,
  output logic [NUM_WAYS*TAG_BITS-1:0] new_tags_o
);

  logic                hit, any_free;
  logic [WAY_BITS-1:0] hit_way, free_way;

  // lowest matching way and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_valid_i[w] && row_tags_i[w*TAG_BITS +: TAG_BITS] == tag_i) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!row_valid_i[w]) begin
        any_free = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    res_o = '0;
    way_o = '0;
    if (hit) begin
      res_o.hit = 1'b1;
      way_o     = hit_way;
    end else if (opcode_i == OP_READ) begin
      res_o.filled  = 1'b1;
      res_o.evicted = !any_free;
      way_o         = any_free ? free_way : victim_i;
    end
  end

  always_comb begin
    new_valid_o = row_valid_i;
    new_tags_o  = row_tags_i;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_o == WAY_BITS'(w)) begin
        new_valid_o[w]                       = 1'b1;
        new_tags_o[w*TAG_BITS +: TAG_BITS] = tag_i;
      end
    end
  end

endmodule

// ===== src/set_assoc_cache_tag_lookup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core
// Tag directory of a set-associative cache, random replacement on read miss,
// no allocation on write miss, wrapping hit and miss counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries opcode, tag and set index.
//   Output channel out_valid_o/out_ready_i carries hit, filled, way_used,
//   evicted and the hit and miss totals after that access.
//   An access is accepted into an input register while its set row is read
//   from the directory memory; once the result register is free it compares
//   tags, writes the row back on a fill and loads the result register.
//   Throughput is one access per cycle while the receiver does not stall. A
//   row written by one access and read by the next is forwarded from a bypass
//   register. After reset the valid bits are cleared one set per cycle, with
//   in_ready_o low; seed writes are taken.
//   The LFSR reloads on a write to the seed port, at once.
//   When the receiver stalls, the result register holds and the pipeline
//   stops behind it; in_ready_o falls once the input register is also full.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_core
  import sactl_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int SET_BITS = $clog2(NUM_SETS),
  localparam int WAY_BITS = $clog2(NUM_WAYS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SEED_W-1:0]   replace_seed_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic [SET_BITS-1:0] set_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic                filled_o,
  output logic [WAY_BITS-1:0] way_used_o,
  output logic                evicted_o,
  output logic [63:0]         hit_total_o,
  output logic [63:0]         miss_total_o
);

  localparam bit SETS_POW2 = (NUM_SETS == (1 << SET_BITS));
  localparam int ROW_W     = NUM_WAYS * TAG_BITS;

  logic                mem_busy;
  logic                in_xfer, s2_fire;
  logic [SET_BITS-1:0] set_red;

  logic                s1_valid_q;
  logic                op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [SET_BITS-1:0] set_q;

  logic                fwd_q;
  logic [NUM_WAYS-1:0] fwd_valid_q;
  logic [ROW_W-1:0]    fwd_tags_q;

  logic [NUM_WAYS-1:0] mem_valid, row_valid, new_valid;
  logic [ROW_W-1:0]    mem_tags, row_tags, new_tags;
  logic [WAY_BITS-1:0] victim, way;
  sactl_res_t          res;

  logic                out_valid_q;
  logic                hit_q, filled_q, evicted_q;
  logic [WAY_BITS-1:0] way_q;
  logic [63:0]         hit_cnt_q, miss_cnt_q;

  assign set_red = (SETS_POW2 || set_index_i < SET_BITS'(NUM_SETS)) ?
                   set_index_i : set_index_i - SET_BITS'(NUM_SETS);

  assign s2_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !mem_busy && (!s1_valid_q || s2_fire);
  assign in_xfer    = in_valid_i && in_ready_o;

  sactl_dir_mem #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS),
    .TAG_BITS(TAG_BITS)
  ) u_dir_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (set_red),
    .rd_valid_o(mem_valid),
    .rd_tags_o (mem_tags),
    .wr_en_i   (s2_fire && res.filled),
    .wr_addr_i (set_q),
    .wr_valid_i(new_valid),
    .wr_tags_i (new_tags),
    .busy_o    (mem_busy)
  );

  sactl_lfsr #(
    .NUM_WAYS(NUM_WAYS)
  ) u_lfsr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .seed_i   (replace_seed_i),
    .advance_i(s2_fire && res.evicted),
    .victim_o (victim)
  );

  // row written back in the same cycle as this read is taken from the bypass
  assign row_valid = fwd_q ? fwd_valid_q : mem_valid;
  assign row_tags  = fwd_q ? fwd_tags_q  : mem_tags;

  sactl_lookup #(
    .NUM_WAYS(NUM_WAYS),
    .TAG_BITS(TAG_BITS)
  ) u_lookup (
    .opcode_i   (op_q),
    .tag_i      (tag_q),
    .row_valid_i(row_valid),
    .row_tags_i (row_tags),
    .victim_i   (victim),
    .res_o      (res),
    .way_o      (way),
    .new_valid_o(new_valid),
    .new_tags_o (new_tags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s2_fire && res.filled && (set_q == set_red);
      end else if (s2_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= opcode_i;
      tag_q       <= tag_i;
      set_q       <= set_red;
      fwd_valid_q <= new_valid;
      fwd_tags_q  <= new_tags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else begin
      if (s2_fire) begin
        out_valid_q <= 1'b1;
        if (res.hit) begin
          hit_cnt_q <= hit_cnt_q + 64'd1;
        end else begin
          miss_cnt_q <= miss_cnt_q + 64'd1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      hit_q     <= res.hit;
      filled_q  <= res.filled;
      evicted_q <= res.evicted;
      way_q     <= way;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign filled_o     = filled_q;
  assign evicted_o    = evicted_q;
  assign way_used_o   = way_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

endmodule

// ===== src/sactl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactl_checker
// Port-level checks of the cache tag lookup, bound to the top level.
// ----------------------------------------------------------------------------
module sactl_checker
  import sactl_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int SET_BITS = $clog2(NUM_SETS),
  localparam int WAY_BITS = $clog2(NUM_WAYS)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [SEED_W-1:0]   replace_seed_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                opcode_i,
  input logic [TAG_BITS-1:0] tag_i,
  input logic [SET_BITS-1:0] set_index_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                hit_o,
  input logic                filled_o,
  input logic [WAY_BITS-1:0] way_used_o,
  input logic                evicted_o,
  input logic [63:0]         hit_total_o,
  input logic [63:0]         miss_total_o
);

  logic [63:0] total;

  assign total = hit_total_o + miss_total_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_o || !filled_o) |-> !evicted_o && !(hit_o && filled_o))
    else $error("fill or eviction flagged without a miss fill");

  a_write_miss_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o && !filled_o |-> way_used_o == '0)
    else $error("way not zero on write miss");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o || total == $past(total) + 64'd1)
    else $error("access counters did not advance by one");

endmodule

bind set_assoc_cache_tag_lookup_core sactl_checker #(
  .NUM_SETS(NUM_SETS),
  .NUM_WAYS(NUM_WAYS),
  .TAG_BITS(TAG_BITS)
) u_sactl_checker (.*);
